FILE: sv/vertex_scale_rotate_translate_core_defines.svh
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared property forms for the vertex scale/rotate/translate core.
// ----------------------------------------------------------------------------
`ifndef VERTEX_SCALE_ROTATE_TRANSLATE_CORE_DEFINES_SVH
`define VERTEX_SCALE_ROTATE_TRANSLATE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold once the delay dly has passed after the antecedent.
`define VSRT_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

FILE: sv/vsrt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, register indexes and pipeline depths shared by the core.
// ----------------------------------------------------------------------------
package vsrt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_WIDTH_DEF  = 16;

    localparam int SCALE_WIDTH = 16;
    localparam int SCALE_FRAC  = 8;
    localparam int SCALE_REG_W = 3 * SCALE_WIDTH;
    localparam int TEX_WIDTH   = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // every scale 1.0 in Q8.8
    localparam logic [SCALE_REG_W-1:0] SCALE_RESET = 48'h0100_0100_0100;

    localparam int SCALE_STAGES  = 2;
    localparam int ROT_STAGES    = 2;
    localparam int XFORM_LATENCY = SCALE_STAGES + 3 * ROT_STAGES;
    localparam int CORE_LATENCY  = XFORM_LATENCY + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSLATE_X = 3'd0,
        CFG_TRANSLATE_Y = 3'd1,
        CFG_TRANSLATE_Z = 3'd2,
        CFG_SCALE_XYZ   = 3'd3,
        CFG_ROT_X       = 3'd4,
        CFG_ROT_Y       = 3'd5,
        CFG_ROT_Z       = 3'd6
    } t_cfg_idx;

endpackage

FILE: sv/vertex_scale_rotate_translate_core.sv
// ----------------------------------------------------------------------------
// Vertex scale / rotate / translate core
// Throughput: one item per cycle; o_busy is high in reset and the cycle after.
// Stages: 2 scale, 2 per rotation axis, 1 translate and output register.
// Reset (sync, active low) clears the pipeline valid bits and loads the
// identity transform into the configuration registers.
// ----------------------------------------------------------------------------
`include "vertex_scale_rotate_translate_core_defines.svh"

module vertex_scale_rotate_translate_core
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = TRIG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_norm_x,
    input  logic signed [COORD_WIDTH-1:0] i_norm_y,
    input  logic signed [COORD_WIDTH-1:0] i_norm_z,
    input  logic [TEX_WIDTH-1:0]          i_tex_u,
    input  logic [TEX_WIDTH-1:0]          i_tex_v,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_out_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_out_pos_z,
    output logic signed [COORD_WIDTH-1:0] o_out_norm_x,
    output logic signed [COORD_WIDTH-1:0] o_out_norm_y,
    output logic signed [COORD_WIDTH-1:0] o_out_norm_z,
    output logic [TEX_WIDTH-1:0]          o_out_tex_u,
    output logic [TEX_WIDTH-1:0]          o_out_tex_v,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int EW = COORD_WIDTH + 1;
    localparam logic [2*TRIG_WIDTH-1:0] ROT_RESET =
        {TRIG_WIDTH'(1) << (TRIG_WIDTH - 2), TRIG_WIDTH'(0)};

    function automatic logic [COORD_WIDTH-1:0] f_sat(input logic [EW-1:0] v);
        if (v[EW-1] == v[EW-2]) begin
            f_sat = v[COORD_WIDTH-1:0];
        end else if (v[EW-1]) begin
            f_sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            f_sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic                          r_busy;
    logic                          w_accept;

    logic signed [COORD_WIDTH-1:0] r_trans_x, r_trans_y, r_trans_z;
    logic [SCALE_REG_W-1:0]        r_scale;
    logic [2*TRIG_WIDTH-1:0]       r_rot_x, r_rot_y, r_rot_z;

    logic signed [COORD_WIDTH-1:0] w_pos_in  [3];
    logic signed [COORD_WIDTH-1:0] w_norm_in [3];
    logic signed [COORD_WIDTH-1:0] w_pos     [3];
    logic signed [COORD_WIDTH-1:0] w_norm    [3];
    logic signed [COORD_WIDTH-1:0] w_trans   [3];
    logic                          w_pos_vld;
    logic                          w_norm_vld;

    logic signed [COORD_WIDTH-1:0] r_pos_out  [3];
    logic signed [COORD_WIDTH-1:0] r_norm_out [3];
    logic                          r_vld_out;
    logic [TEX_WIDTH-1:0]          r_tex_u [CORE_LATENCY];
    logic [TEX_WIDTH-1:0]          r_tex_v [CORE_LATENCY];

    // busy while in reset and for the first cycle out of it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy      = r_busy;
    assign w_accept    = i_start & ~r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_x <= '0;
            r_trans_y <= '0;
            r_trans_z <= '0;
            r_scale   <= SCALE_RESET;
            r_rot_x   <= ROT_RESET;
            r_rot_y   <= ROT_RESET;
            r_rot_z   <= ROT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRANSLATE_X: r_trans_x <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_TRANSLATE_Y: r_trans_y <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_TRANSLATE_Z: r_trans_z <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_SCALE_XYZ:   r_scale   <= i_cfg_data[SCALE_REG_W-1:0];
                CFG_ROT_X:       r_rot_x   <= i_cfg_data[2*TRIG_WIDTH-1:0];
                CFG_ROT_Y:       r_rot_y   <= i_cfg_data[2*TRIG_WIDTH-1:0];
                CFG_ROT_Z:       r_rot_z   <= i_cfg_data[2*TRIG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign w_pos_in[0]  = i_pos_x;
    assign w_pos_in[1]  = i_pos_y;
    assign w_pos_in[2]  = i_pos_z;
    assign w_norm_in[0] = i_norm_x;
    assign w_norm_in[1] = i_norm_y;
    assign w_norm_in[2] = i_norm_z;

    vsrt_transform #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_v     (w_pos_in),
        .i_scale (r_scale),
        .i_rot_x (r_rot_x),
        .i_rot_y (r_rot_y),
        .i_rot_z (r_rot_z),
        .o_vld   (w_pos_vld),
        .o_v     (w_pos)
    );

    vsrt_transform #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_v     (w_norm_in),
        .i_scale (r_scale),
        .i_rot_x (r_rot_x),
        .i_rot_y (r_rot_y),
        .i_rot_z (r_rot_z),
        .o_vld   (w_norm_vld),
        .o_v     (w_norm)
    );

    assign w_trans[0] = r_trans_x;
    assign w_trans[1] = r_trans_y;
    assign w_trans[2] = r_trans_z;

    // translate the position; the normal only takes the matching register
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pos_out[k]  <= f_sat(EW'(w_pos[k]) + EW'(w_trans[k]));
            r_norm_out[k] <= w_norm[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else begin
            r_vld_out <= w_pos_vld;
        end
    end

    // texture coordinates follow the item down a plain delay line
    always_ff @(posedge i_clk) begin
        r_tex_u[0] <= i_tex_u;
        r_tex_v[0] <= i_tex_v;
        for (int k = 1; k < CORE_LATENCY; k++) begin
            r_tex_u[k] <= r_tex_u[k-1];
            r_tex_v[k] <= r_tex_v[k-1];
        end
    end

    assign o_valid      = r_vld_out;
    assign o_out_pos_x  = r_pos_out[0];
    assign o_out_pos_y  = r_pos_out[1];
    assign o_out_pos_z  = r_pos_out[2];
    assign o_out_norm_x = r_norm_out[0];
    assign o_out_norm_y = r_norm_out[1];
    assign o_out_norm_z = r_norm_out[2];
    assign o_out_tex_u  = r_tex_u[CORE_LATENCY-1];
    assign o_out_tex_v  = r_tex_v[CORE_LATENCY-1];

    `VSRT_ASSERT_NOW(a_lanes_aligned, i_clk, i_rst_n, 1'b1, (w_pos_vld == w_norm_vld), "position and normal lanes out of step")
    `VSRT_ASSERT_AFTER(a_item_latency, i_clk, i_rst_n, w_accept, CORE_LATENCY, o_valid, "accepted item did not come out on time")
    `VSRT_ASSERT_AFTER(a_tex_follows, i_clk, i_rst_n, w_accept, CORE_LATENCY, (o_out_tex_u == $past(i_tex_u, CORE_LATENCY)), "texture U not aligned with its item")

endmodule

FILE: sv/vsrt_scale.sv
// ----------------------------------------------------------------------------
// Vertex per-axis scale
// Two stages: signed multiply by Q8.8 scale, then round half up and saturate.
// ----------------------------------------------------------------------------
module vsrt_scale
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_v [3],
    input  logic [SCALE_REG_W-1:0]        i_scale,
    output logic                          o_vld,
    output logic signed [COORD_WIDTH-1:0] o_v [3]
);

    localparam int PW = COORD_WIDTH + SCALE_WIDTH;
    localparam int EW = PW - SCALE_FRAC;
    localparam logic [PW-1:0] ROUND = PW'(1) << (SCALE_FRAC - 1);

    function automatic logic [COORD_WIDTH-1:0] f_sat(input logic [EW-1:0] v);
        logic [EW-COORD_WIDTH:0] l_hi;
        l_hi = v[EW-1:COORD_WIDTH-1];
        if (&l_hi || ~|l_hi) begin
            f_sat = v[COORD_WIDTH-1:0];
        end else if (v[EW-1]) begin
            f_sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            f_sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic signed [PW-1:0] r_prod [3];
    logic signed [PW-1:0] w_rnd  [3];
    logic                 r_vld1;
    logic                 r_vld2;

    // x scale sits in the top field, z in the bottom one
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= i_v[k] * $signed(i_scale[(2 - k) * SCALE_WIDTH +: SCALE_WIDTH]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = r_prod[k] + $signed(ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            o_v[k] <= f_sat(w_rnd[k][PW-1:SCALE_FRAC]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;

endmodule

FILE: sv/vsrt_rotate.sv
// ----------------------------------------------------------------------------
// Vertex planar rotation
// (a, b) -> (a*c - b*s, a*s + b*c); products in one stage, sum, round
// and saturate in the next. A third component rides along unchanged.
// ----------------------------------------------------------------------------
module vsrt_rotate
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = TRIG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    input  logic signed [COORD_WIDTH-1:0] i_c,
    input  logic [2*TRIG_WIDTH-1:0]       i_cos_sin,
    output logic                          o_vld,
    output logic signed [COORD_WIDTH-1:0] o_a,
    output logic signed [COORD_WIDTH-1:0] o_b,
    output logic signed [COORD_WIDTH-1:0] o_c
);

    localparam int PW   = COORD_WIDTH + TRIG_WIDTH;
    localparam int FRAC = TRIG_WIDTH - 2;
    localparam int EW   = PW + 1 - FRAC;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC - 1);

    function automatic logic [COORD_WIDTH-1:0] f_sat(input logic [EW-1:0] v);
        logic [EW-COORD_WIDTH:0] l_hi;
        l_hi = v[EW-1:COORD_WIDTH-1];
        if (&l_hi || ~|l_hi) begin
            f_sat = v[COORD_WIDTH-1:0];
        end else if (v[EW-1]) begin
            f_sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            f_sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic signed [TRIG_WIDTH-1:0]  w_cos;
    logic signed [TRIG_WIDTH-1:0]  w_sin;
    logic signed [PW-1:0]          r_ac;
    logic signed [PW-1:0]          r_bs;
    logic signed [PW-1:0]          r_as;
    logic signed [PW-1:0]          r_bc;
    logic signed [COORD_WIDTH-1:0] r_c;
    logic signed [PW:0]            w_sum_a;
    logic signed [PW:0]            w_sum_b;
    logic                          r_vld1;
    logic                          r_vld2;

    assign w_cos = $signed(i_cos_sin[2*TRIG_WIDTH-1:TRIG_WIDTH]);
    assign w_sin = $signed(i_cos_sin[TRIG_WIDTH-1:0]);

    always_ff @(posedge i_clk) begin
        r_ac <= i_a * w_cos;
        r_bs <= i_b * w_sin;
        r_as <= i_a * w_sin;
        r_bc <= i_b * w_cos;
        r_c  <= i_c;
    end

    // exact sums, then half-up rounding before the arithmetic shift
    assign w_sum_a = r_ac - r_bs + $signed(HALF);
    assign w_sum_b = r_as + r_bc + $signed(HALF);

    always_ff @(posedge i_clk) begin
        o_a <= f_sat(w_sum_a[PW:FRAC]);
        o_b <= f_sat(w_sum_b[PW:FRAC]);
        o_c <= r_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;

endmodule

FILE: sv/vsrt_transform.sv
// ----------------------------------------------------------------------------
// Vertex scale and XYZ rotation chain
// Scale, then rotate about X, Y and Z; one item may enter every cycle.
// ----------------------------------------------------------------------------
module vsrt_transform
    import vsrt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = TRIG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_v [3],
    input  logic [SCALE_REG_W-1:0]        i_scale,
    input  logic [2*TRIG_WIDTH-1:0]       i_rot_x,
    input  logic [2*TRIG_WIDTH-1:0]       i_rot_y,
    input  logic [2*TRIG_WIDTH-1:0]       i_rot_z,
    output logic                          o_vld,
    output logic signed [COORD_WIDTH-1:0] o_v [3]
);

    logic                          w_s_vld;
    logic signed [COORD_WIDTH-1:0] w_s [3];
    logic                          w_rx_vld;
    logic signed [COORD_WIDTH-1:0] w_rx_y, w_rx_z, w_rx_x;
    logic                          w_ry_vld;
    logic signed [COORD_WIDTH-1:0] w_ry_z, w_ry_x, w_ry_y;

    vsrt_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_v     (i_v),
        .i_scale (i_scale),
        .o_vld   (w_s_vld),
        .o_v     (w_s)
    );

    // about X: (y, z) rotate, x rides along
    vsrt_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH)
    ) u_rot_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_s_vld),
        .i_a       (w_s[1]),
        .i_b       (w_s[2]),
        .i_c       (w_s[0]),
        .i_cos_sin (i_rot_x),
        .o_vld     (w_rx_vld),
        .o_a       (w_rx_y),
        .o_b       (w_rx_z),
        .o_c       (w_rx_x)
    );

    // about Y: (z, x) rotate
    vsrt_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH)
    ) u_rot_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_rx_vld),
        .i_a       (w_rx_z),
        .i_b       (w_rx_x),
        .i_c       (w_rx_y),
        .i_cos_sin (i_rot_y),
        .o_vld     (w_ry_vld),
        .o_a       (w_ry_z),
        .o_b       (w_ry_x),
        .o_c       (w_ry_y)
    );

    // about Z: (x, y) rotate
    vsrt_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH)
    ) u_rot_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_ry_vld),
        .i_a       (w_ry_x),
        .i_b       (w_ry_y),
        .i_c       (w_ry_z),
        .i_cos_sin (i_rot_z),
        .o_vld     (o_vld),
        .o_a       (o_v[0]),
        .o_b       (o_v[1]),
        .o_c       (o_v[2])
    );

endmodule

FILE: bench/vertex_scale_rotate_translate_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex scale / rotate / translate core testbench
// Walks a directed table of register writes and vertices, then fixed and
// random transform phases with random vertices. Each expected vertex comes
// from the table or a fixed-point model here when it is accepted, and every
// output strobe is compared field by field against the oldest pending vertex.
// ----------------------------------------------------------------------------
module vertex_scale_rotate_translate_core_test;
    import vsrt_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TW = TRIG_WIDTH_DEF;

    localparam logic [CW-1:0] POS_FULL = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_FULL = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [2*TW-1:0] ROT_IDENTITY = {16'h4000, 16'h0000};
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;

    typedef struct packed {
        logic [CW-1:0]        px, py, pz;
        logic [CW-1:0]        nx, ny, nz;
        logic [TEX_WIDTH-1:0] tu, tv;
    } t_vertex;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_vertex               vtx;
        bit                    typed;
        t_vertex               want;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic signed [CW-1:0]          i_pos_x, i_pos_y, i_pos_z;
    logic signed [CW-1:0]          i_norm_x, i_norm_y, i_norm_z;
    logic [TEX_WIDTH-1:0]          i_tex_u, i_tex_v;
    logic                          o_valid;
    logic signed [CW-1:0]          o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [CW-1:0]          o_out_norm_x, o_out_norm_y, o_out_norm_z;
    logic [TEX_WIDTH-1:0]          o_out_tex_u, o_out_tex_v;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    // shadow copy of the transform registers
    logic signed [CW-1:0]   shift_x, shift_y, shift_z;
    logic [SCALE_REG_W-1:0] scale_reg;
    logic [2*TW-1:0]        rot_x_reg, rot_y_reg, rot_z_reg;

    t_vertex   outbound_vertices[$];
    t_stim_row stimulus_rows[$];
    int        mismatch_count = 0;

    vertex_scale_rotate_translate_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_norm_x     (i_norm_x),
        .i_norm_y     (i_norm_y),
        .i_norm_z     (i_norm_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .o_valid      (o_valid),
        .o_out_pos_x  (o_out_pos_x),
        .o_out_pos_y  (o_out_pos_y),
        .o_out_pos_z  (o_out_pos_z),
        .o_out_norm_x (o_out_norm_x),
        .o_out_norm_y (o_out_norm_y),
        .o_out_norm_z (o_out_norm_z),
        .o_out_tex_u  (o_out_tex_u),
        .o_out_tex_v  (o_out_tex_v),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    // ---------------- fixed-point transform ----------------

    function automatic longint clamp_coord(input longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // round half up, then arithmetic shift
    function automatic longint half_up_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint scale_axis(input logic signed [CW-1:0] p,
                                          input logic signed [SCALE_WIDTH-1:0] s);
        return clamp_coord(half_up_shift(longint'(p) * longint'(s), SCALE_FRAC));
    endfunction

    // (a, b) -> (a*c - b*s, a*s + b*c)
    function automatic void planar_turn(inout longint a, inout longint b,
                                        input logic [2*TW-1:0] cs);
        logic signed [TW-1:0] c, s;
        longint na, nb;
        c = cs[2*TW-1:TW];
        s = cs[TW-1:0];
        na = clamp_coord(half_up_shift(a * longint'(c) - b * longint'(s), TW - 2));
        nb = clamp_coord(half_up_shift(a * longint'(s) + b * longint'(c), TW - 2));
        a = na;
        b = nb;
    endfunction

    function automatic void scale_rotate(input logic [CW-1:0] ix, iy, iz,
                                         output longint ox, oy, oz);
        longint x, y, z;
        x = scale_axis(ix, scale_reg[47:32]);
        y = scale_axis(iy, scale_reg[31:16]);
        z = scale_axis(iz, scale_reg[15:0]);
        planar_turn(y, z, rot_x_reg);
        planar_turn(z, x, rot_y_reg);
        planar_turn(x, y, rot_z_reg);
        ox = x;
        oy = y;
        oz = z;
    endfunction

    function automatic t_vertex transform_vertex(input t_vertex v);
        t_vertex r;
        longint x, y, z;
        scale_rotate(v.px, v.py, v.pz, x, y, z);
        r.px = CW'(clamp_coord(x + longint'(shift_x)));
        r.py = CW'(clamp_coord(y + longint'(shift_y)));
        r.pz = CW'(clamp_coord(z + longint'(shift_z)));
        scale_rotate(v.nx, v.ny, v.nz, x, y, z);
        r.nx = CW'(x);
        r.ny = CW'(y);
        r.nz = CW'(z);
        r.tu = v.tu;
        r.tv = v.tv;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_vertex mk_vertex(input logic [CW-1:0] px, py, pz, nx, ny, nz,
                                          input logic [TEX_WIDTH-1:0] tu, tv);
        t_vertex v;
        v = '{px, py, pz, nx, ny, nz, tu, tv};
        return v;
    endfunction

    function automatic void add_item(input t_vertex v, input bit typed, input t_vertex want);
        t_stim_row r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.vtx      = v;
        r.typed    = typed;
        r.want     = want;
        stimulus_rows.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        r.vtx      = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        stimulus_rows.push_back(r);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7)) inside
            [0:2]:   return r;
            3:       return {{11{r[20]}}, r[20:0]};
            4:       return {{3{r[28]}}, r[28:0]};
            5:       return {{28{r[3]}}, r[3:0]};
            6:       return POS_FULL;
            default: return NEG_FULL;
        endcase
    endfunction

    function automatic logic [TW-1:0] rand_trig();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 7)) inside
            [0:1]:   return r;
            [2:3]:   return {{2{r[13]}}, r[13:0]};
            4:       return 16'h4000;
            5:       return 16'h0000;
            6:       return 16'hc000;
            default: return r[0] ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    function automatic logic [SCALE_WIDTH-1:0] rand_scale();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 6)) inside
            [0:1]:   return r;
            [2:3]:   return 16'h0100 + {{10{r[5]}}, r[5:0]};
            4:       return 16'h0100;
            5:       return 16'hff00;
            default: return r[0] ? 16'h7fff : (r[1] ? 16'h8000 : 16'h0000);
        endcase
    endfunction

    // ---------------- drivers ----------------

    // leaves i_cfg_valid high; the next item or write takes it over
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TRANSLATE_X: shift_x   = data[CW-1:0];
            CFG_TRANSLATE_Y: shift_y   = data[CW-1:0];
            CFG_TRANSLATE_Z: shift_z   = data[CW-1:0];
            CFG_SCALE_XYZ:   scale_reg = data[SCALE_REG_W-1:0];
            CFG_ROT_X:       rot_x_reg = data[2*TW-1:0];
            CFG_ROT_Y:       rot_y_reg = data[2*TW-1:0];
            CFG_ROT_Z:       rot_z_reg = data[2*TW-1:0];
            default: ;
        endcase
    endtask

    // leaves i_start high so back-to-back items need no extra edge
    task automatic push_vertex(input t_vertex v, input bit typed, input t_vertex want);
        i_cfg_valid <= 1'b0;
        i_start     <= 1'b1;
        i_pos_x     <= v.px;
        i_pos_y     <= v.py;
        i_pos_z     <= v.pz;
        i_norm_x    <= v.nx;
        i_norm_y    <= v.ny;
        i_norm_z    <= v.nz;
        i_tex_u     <= v.tu;
        i_tex_v     <= v.tv;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        outbound_vertices.push_back(typed ? want : transform_vertex(v));
    endtask

    task automatic sender_gap(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outbound_vertices.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_phase(input int mode);
        logic [CW-1:0]          tx, ty, tz;
        logic [SCALE_REG_W-1:0] sc;
        logic [2*TW-1:0]        rx, ry, rz;
        bit                     unused_first;
        case (mode)
            0: begin
                {tx, ty, tz} = '0;
                sc = SCALE_RESET;
                {rx, ry, rz} = {3{ROT_IDENTITY}};
            end
            1: begin
                {tx, ty, tz} = {3{POS_FULL}};
                sc = {3{16'h7fff}};
                {rx, ry, rz} = {6{16'h7fff}};
            end
            2: begin
                {tx, ty, tz} = {3{NEG_FULL}};
                sc = {3{16'h8000}};
                {rx, ry, rz} = {6{16'h8000}};
            end
            default: begin
                tx = rand_coord();
                ty = rand_coord();
                tz = rand_coord();
                sc = {rand_scale(), rand_scale(), rand_scale()};
                rx = {rand_trig(), rand_trig()};
                ry = {rand_trig(), rand_trig()};
                rz = {rand_trig(), rand_trig()};
            end
        endcase
        unused_first = 1'($urandom_range(0, 1));
        if (unused_first) write_reg(IDX_UNUSED, {16'($urandom), 32'($urandom)});
        // bits above each register's width are random and must be dropped
        write_reg(CFG_TRANSLATE_X, {16'($urandom), tx});
        write_reg(CFG_TRANSLATE_Y, {16'($urandom), ty});
        write_reg(CFG_TRANSLATE_Z, {16'($urandom), tz});
        write_reg(CFG_SCALE_XYZ, sc);
        write_reg(CFG_ROT_X, {16'($urandom), rx});
        write_reg(CFG_ROT_Y, {16'($urandom), ry});
        write_reg(CFG_ROT_Z, {16'($urandom), rz});
        if (!unused_first) write_reg(IDX_UNUSED, {16'($urandom), 32'($urandom)});
    endtask

    // ---------------- checking ----------------

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got, want);
        if (got !== want) flag_mismatch($sformatf("%s got %h want %h", field, got, want));
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_valid) begin
            if (outbound_vertices.size() == 0) begin
                flag_mismatch($sformatf("unexpected vertex, pos_x %h", o_out_pos_x));
            end else begin
                want = outbound_vertices.pop_front();
                check_field("pos_x", o_out_pos_x, want.px);
                check_field("pos_y", o_out_pos_y, want.py);
                check_field("pos_z", o_out_pos_z, want.pz);
                check_field("norm_x", o_out_norm_x, want.nx);
                check_field("norm_y", o_out_norm_y, want.ny);
                check_field("norm_z", o_out_norm_z, want.nz);
                check_field("tex_u", o_out_tex_u, want.tu);
                check_field("tex_v", o_out_tex_v, want.tv);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        t_vertex v;
        bit      after_item;
        int      burst_left;
        int      count;
        int      mode;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_norm_x    <= '0;
        i_norm_y    <= '0;
        i_norm_z    <= '0;
        i_tex_u     <= '0;
        i_tex_v     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        {shift_x, shift_y, shift_z} = '0;
        scale_reg = SCALE_RESET;
        {rot_x_reg, rot_y_reg, rot_z_reg} = {3{ROT_IDENTITY}};

        // identity transform after reset: vertex comes back unchanged
        v = mk_vertex('0, '0, '0, '0, '0, '0, '0, '0);
        add_item(v, 1'b1, v);
        v = mk_vertex(POS_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL, POS_FULL,
                      32'hffff_ffff, 32'hffff_ffff);
        add_item(v, 1'b1, v);
        v = mk_vertex(NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL, NEG_FULL,
                      32'h0, 32'h0);
        add_item(v, 1'b1, v);
        v = mk_vertex(ONE_Q16, 32'hfffd_8000, 32'h0000_8000, 32'h0, ONE_Q16, 32'h0,
                      32'h3f80_0000, 32'hbf00_0000);
        add_item(v, 1'b1, v);

        // translation saturates both ways
        add_write(CFG_TRANSLATE_X, {16'h0, POS_FULL});
        add_write(CFG_TRANSLATE_Y, {16'h0, NEG_FULL});
        add_write(CFG_TRANSLATE_Z, {16'h0, ONE_Q16});
        add_item(mk_vertex(POS_FULL, NEG_FULL, 32'h0, 32'h1, 32'h2, 32'h3, 32'h1, 32'h2), 1'b1,
                 mk_vertex(POS_FULL, NEG_FULL, ONE_Q16, 32'h1, 32'h2, 32'h3, 32'h1, 32'h2));
        add_item(mk_vertex(32'hffff_ffff, POS_FULL, NEG_FULL, 32'h0, 32'h0, 32'h0,
                           32'h5555_5555, 32'haaaa_aaaa), 1'b0, '0);

        // data bits above the translate width are dropped
        add_write(CFG_TRANSLATE_X, 48'hffff_0000_0000);
        add_write(CFG_TRANSLATE_Y, 48'h0);
        add_write(CFG_TRANSLATE_Z, 48'h0);
        // scales at the extremes, overflow in the scaling stage
        add_write(CFG_SCALE_XYZ, 48'h7fff_8000_0200);
        add_item(mk_vertex(POS_FULL, POS_FULL, POS_FULL, NEG_FULL, NEG_FULL, NEG_FULL,
                           32'h0, 32'h1), 1'b0, '0);
        add_item(mk_vertex(ONE_Q16, ONE_Q16, ONE_Q16, 32'hffff_0000, 32'hffff_0000,
                           32'h0000_0080, 32'h7, 32'h8), 1'b0, '0);

        // quarter turn about X, eighth turn about Y, unnormalized pair about Z
        add_write(CFG_ROT_X, {16'h0, 16'h0000, 16'h4000});
        add_write(CFG_ROT_Y, {16'h0, 16'h2d41, 16'h2d41});
        add_write(CFG_ROT_Z, {16'h0, 16'h7fff, 16'h8000});
        add_item(mk_vertex(ONE_Q16, 32'h0002_0000, 32'hfffd_0000, 32'h0, 32'h0, ONE_Q16,
                           32'h1234_5678, 32'h9abc_def0), 1'b0, '0);
        add_item(mk_vertex(POS_FULL, NEG_FULL, POS_FULL, NEG_FULL, POS_FULL, NEG_FULL,
                           32'h0, 32'hffff_ffff), 1'b0, '0);
        add_item(mk_vertex(32'h1, 32'hffff_ffff, 32'h0000_0081, 32'h0000_7fff,
                           32'hffff_8001, 32'h0, 32'h1, 32'h0), 1'b0, '0);
        add_write(CFG_SCALE_XYZ, 48'hff00_0100_8000);
        add_write(CFG_ROT_Z, {16'hffff, 16'h8000, 16'h7fff});
        add_item(mk_vertex(32'h0100_0000, 32'hff00_0000, 32'h0000_0100, NEG_FULL,
                           POS_FULL, 32'h8000_0001, 32'hdead_beef, 32'h0), 1'b0, '0);

        // out-of-range index is ignored: nothing may change
        add_write(IDX_UNUSED, 48'h0);
        add_write(CFG_TRANSLATE_Y, 48'hffff_ffff_0001);
        add_item(mk_vertex(32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0000_4000,
                           32'h0000_c000, 32'hffff_c000, 32'h1, 32'h1), 1'b0, '0);
        add_item(mk_vertex(32'h8000_0001, 32'h7fff_fffe, 32'h0, 32'h1, 32'hffff_ffff,
                           32'h0, 32'h2, 32'h3), 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        after_item = 1'b0;
        foreach (stimulus_rows[k]) begin
            if (stimulus_rows[k].is_write) begin
                if (after_item) wait_idle();
                write_reg(stimulus_rows[k].reg_idx, stimulus_rows[k].reg_data);
                after_item = 1'b0;
            end else begin
                push_vertex(stimulus_rows[k].vtx, stimulus_rows[k].typed,
                            stimulus_rows[k].want);
                after_item = 1'b1;
                if (k + 1 < stimulus_rows.size() && !stimulus_rows[k + 1].is_write &&
                    $urandom_range(0, 1))
                    sender_gap($urandom_range(1, 3));
            end
        end

        // random phases: identity, all-max, all-min, then random settings
        for (int phase = 0; phase < 8; phase++) begin
            mode  = phase;
            count = (mode == 1 || mode == 2) ? 100 : 280;
            wait_idle();
            program_phase(mode);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < count; n++) begin
                push_vertex(mk_vertex(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      $urandom, $urandom), 1'b0, '0);
                burst_left--;
                if (burst_left == 0) begin
                    if (n != count - 1)
                        sender_gap(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                                : $urandom_range(1, 3));
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        wait_idle();
        repeat (CORE_LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/vsrt_pkg.sv
sv/vsrt_scale.sv
sv/vsrt_rotate.sv
sv/vsrt_transform.sv
sv/vertex_scale_rotate_translate_core.sv
bench/vertex_scale_rotate_translate_core_test.sv
